// File: hdl/pavt_pkg.sv
// Package for the potentiometer angle and velocity tracker.
// Holds field widths, request and register codes, reset values, the controller
// state type and the command and status structs. Depends on nothing.
`default_nettype none

package pavt_pkg;

   localparam int unsigned ADC_BITS_DEFAULT = 10;

   localparam int unsigned RANGE_W   = 9;
   localparam int unsigned AGE_W     = 16;
   localparam int unsigned TIME_W    = 32;
   localparam int unsigned TARE_W    = 18;
   localparam int unsigned ANGLE_W   = 19;
   localparam int unsigned VEL_W     = 24;
   localparam int unsigned POS_W     = 17;
   localparam int unsigned REF_W     = 20;
   localparam int unsigned DSW       = 16;
   localparam int unsigned REQ_W     = 2;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DAT_W = 16;

   localparam logic [REQ_W-1:0] REQ_MEASURE = 2'd0;
   localparam logic [REQ_W-1:0] REQ_TICK    = 2'd1;
   localparam logic [REQ_W-1:0] REQ_TARE    = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_RANGE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AGE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TRACK = 2'd2;

   localparam logic [RANGE_W-1:0] RANGE_RESET = 9'd270;
   localparam logic [AGE_W-1:0]   AGE_RESET   = 16'd100;
   localparam logic               TRACK_RESET = 1'b1;

   localparam logic [9:0] VEL_MULT = 10'd1000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_POS_MUL,
      ST_POS_FOLD,
      ST_APPLY,
      ST_VEL_MUL,
      ST_VEL_DIV,
      ST_VEL_WAIT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic capture;
      logic pos_mul;
      logic pos_fold;
      logic pos_load;
      logic apply;
      logic vel_mul;
      logic div_start;
      logic vel_load;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic [REQ_W-1:0] req_code;
      logic             fold_done;
      logic             div_done;
      logic             vel_ok;
      logic             out_free;
   } status_type;

endpackage

`default_nettype wire

// File: hdl/pavt_divider.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Unsigned dividend of DIVW bits over a divisor of pavt_pkg::DSW bits.
// Depends on pavt_pkg.
`default_nettype none

module pavt_divider #(
   parameter int unsigned DIVW = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [DIVW-1:0]          dividend,
   input  logic [pavt_pkg::DSW-1:0] divisor,
   output logic                     done,
   output logic [DIVW-1:0]          quotient
);

   localparam int unsigned CNT_W = $clog2(DIVW + 1);

   logic [DIVW-1:0]          quo_ff, quo_in;
   logic [pavt_pkg::DSW-1:0] rem_ff, rem_in;
   logic [pavt_pkg::DSW-1:0] div_ff, div_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;

   logic [pavt_pkg::DSW:0]   rem_shift;
   logic [pavt_pkg::DSW+1:0] diff;
   logic                     ge;

   assign rem_shift = {rem_ff, quo_ff[DIVW-1]};
   assign diff      = {1'b0, rem_shift} - {2'b00, div_ff};
   assign ge        = ~diff[pavt_pkg::DSW+1];

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = CNT_W'(DIVW);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIVW-2:0], ge};
         rem_in = ge ? diff[pavt_pkg::DSW-1:0] : rem_shift[pavt_pkg::DSW-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// File: hdl/pavt_datapath.sv
// Datapath of the tracker: configuration registers, zero offset, the two
// reference slots, the multipliers, the position scaling, the velocity divider
// and the result register. Depends on pavt_pkg and pavt_divider.
`default_nettype none

module pavt_datapath #(
   parameter int unsigned ADC_BITS = pavt_pkg::ADC_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  pavt_pkg::cmd_type                   cmd,
   output pavt_pkg::status_type                status,
   input  logic [pavt_pkg::REQ_W-1:0]          req_type,
   input  logic [ADC_BITS-1:0]                 req_adc_raw,
   input  logic [pavt_pkg::TIME_W-1:0]         req_now_ms,
   input  logic signed [pavt_pkg::TARE_W-1:0]  req_tare_angle,
   input  logic                                csr_write,
   input  logic [pavt_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pavt_pkg::CSR_DAT_W-1:0]      csr_data,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output logic signed [pavt_pkg::ANGLE_W-1:0] rsp_angle,
   output logic signed [pavt_pkg::VEL_W-1:0]   rsp_velocity,
   output logic                                rsp_velocity_valid
);

   localparam int unsigned PROD_W = ADC_BITS + pavt_pkg::RANGE_W + 8;
   localparam int unsigned DIVW   = (PROD_W > 32) ? PROD_W : 32;
   localparam int unsigned HI_W   = DIVW - ADC_BITS;
   localparam int unsigned RW     = pavt_pkg::REF_W;
   localparam int unsigned TW     = pavt_pkg::TIME_W;
   localparam int unsigned AW     = pavt_pkg::AGE_W;
   localparam int unsigned VW     = pavt_pkg::VEL_W;

   logic [pavt_pkg::REQ_W-1:0]   req_ff;
   logic [ADC_BITS-1:0]          raw_ff;
   logic [TW-1:0]                now_ff;
   logic [pavt_pkg::TARE_W-1:0]  tare_ff;

   logic [pavt_pkg::RANGE_W-1:0] range_ff;
   logic [AW-1:0]                age_ff;
   logic                         track_ff;

   logic [RW-1:0] zero_ff, zero_in;
   logic [RW-1:0] ref_pos0_ff, ref_pos0_in, ref_pos1_ff, ref_pos1_in;
   logic [TW-1:0] ref_time0_ff, ref_time0_in, ref_time1_ff, ref_time1_in;
   logic          sel_ff, sel_in;

   logic [DIVW-1:0]              prod_ff;
   logic [pavt_pkg::POS_W-1:0]   pos_acc_ff;
   logic [pavt_pkg::POS_W-1:0]   pos_ff;
   logic [RW+1:0]                mv_ff;
   logic [AW-1:0]                el_ff;
   logic                         vel_ok_ff;
   logic                         neg_ff;
   logic [VW-1:0]                vel_ff, vel_in;
   logic                         vvalid_ff;

   logic                         rsp_valid_ff;
   logic [pavt_pkg::ANGLE_W-1:0] rsp_angle_ff;
   logic [VW-1:0]                rsp_vel_ff;
   logic                         rsp_vv_ff;

   logic [ADC_BITS+pavt_pkg::RANGE_W-1:0] raw_range;
   logic [HI_W-1:0]     fold_hi;
   logic [ADC_BITS-1:0] fold_lo;
   logic [DIVW-1:0]     fold_sum;
   logic                fold_done;
   logic [RW:0]    angle;
   logic [RW-1:0]  ref_pos_sel;
   logic [TW-1:0]  time_sel, time_oth, el, oel, oel_eff;
   logic [AW-1:0]  half, quarter;
   logic           ok, refill, swap, tick_go;
   logic [RW+1:0]  mv;
   logic [RW-1:0]  nz, delta;
   logic [RW+1:0]  mv_abs;
   logic [31:0]    vel_prod;
   logic [DIVW-1:0] quotient;
   logic           div_done;
   logic           q_big, q_over;
   logic [pavt_pkg::ANGLE_W-1:0] angle_sat;
   logic           out_free;

   pavt_divider #(.DIVW(DIVW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (prod_ff),
      .divisor  (el_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   assign raw_range = raw_ff * range_ff;

   // The product is divided by 2^ADC_BITS - 1 by folding its high part onto its low part.
   assign fold_hi   = prod_ff[DIVW-1:ADC_BITS];
   assign fold_lo   = prod_ff[ADC_BITS-1:0];
   assign fold_sum  = {{ADC_BITS{1'b0}}, fold_hi} + {{HI_W{1'b0}}, fold_lo};
   assign fold_done = (fold_hi == '0);

   assign angle = {{(RW + 1 - pavt_pkg::POS_W){1'b0}}, pos_ff} - {zero_ff[RW-1], zero_ff};

   assign ref_pos_sel = sel_ff ? ref_pos1_ff : ref_pos0_ff;
   assign time_sel    = sel_ff ? ref_time1_ff : ref_time0_ff;
   assign time_oth    = sel_ff ? ref_time0_ff : ref_time1_ff;
   assign el          = now_ff - time_sel;
   assign oel         = now_ff - time_oth;
   assign ok          = (time_sel != '0) && (el != '0) && (el <= TW'(age_ff));
   assign mv          = {angle[RW], angle} - {{2{ref_pos_sel[RW-1]}}, ref_pos_sel};
   assign half        = age_ff >> 1;
   assign quarter     = age_ff >> 2;
   assign tick_go     = track_ff && (el != '0);
   assign refill      = oel >= TW'(half);
   assign oel_eff     = refill ? '0 : oel;
   assign swap        = oel_eff >= TW'(quarter);
   assign nz          = {{(RW - pavt_pkg::POS_W){1'b0}}, pos_ff}
                        - {{(RW - pavt_pkg::TARE_W){tare_ff[pavt_pkg::TARE_W-1]}}, tare_ff};
   assign delta       = nz - zero_ff;

   assign mv_abs   = mv_ff[RW+1] ? (~mv_ff + 1'b1) : mv_ff;
   assign vel_prod = mv_abs * pavt_pkg::VEL_MULT;

   assign q_big  = |quotient[DIVW-1:VW];
   assign q_over = q_big || quotient[VW-1];

   always_comb begin
      vel_in = quotient[VW-1:0];
      if (neg_ff) begin
         if (q_big || (quotient[VW-1] && (|quotient[VW-2:0]))) begin
            vel_in = {1'b1, {(VW - 1){1'b0}}};
         end else begin
            vel_in = ~quotient[VW-1:0] + 1'b1;
         end
      end else if (q_over) begin
         vel_in = {1'b0, {(VW - 1){1'b1}}};
      end
   end

   always_comb begin
      if (angle[RW:pavt_pkg::ANGLE_W-1] == '0 || angle[RW:pavt_pkg::ANGLE_W-1] == '1) begin
         angle_sat = angle[pavt_pkg::ANGLE_W-1:0];
      end else if (angle[RW]) begin
         angle_sat = {1'b1, {(pavt_pkg::ANGLE_W - 1){1'b0}}};
      end else begin
         angle_sat = {1'b0, {(pavt_pkg::ANGLE_W - 1){1'b1}}};
      end
   end

   always_comb begin
      zero_in      = zero_ff;
      ref_pos0_in  = ref_pos0_ff;
      ref_pos1_in  = ref_pos1_ff;
      ref_time0_in = ref_time0_ff;
      ref_time1_in = ref_time1_ff;
      sel_in       = sel_ff;
      if (cmd.apply) begin
         case (req_ff)
            pavt_pkg::REQ_TICK: begin
               if (tick_go) begin
                  if (refill) begin
                     if (sel_ff) begin
                        ref_time0_in = now_ff;
                        ref_pos0_in  = angle[RW-1:0];
                     end else begin
                        ref_time1_in = now_ff;
                        ref_pos1_in  = angle[RW-1:0];
                     end
                  end
                  if (swap) begin
                     sel_in = ~sel_ff;
                  end
               end
            end
            pavt_pkg::REQ_TARE: begin
               if (track_ff) begin
                  ref_pos0_in = ref_pos0_ff + delta;
                  ref_pos1_in = ref_pos1_ff + delta;
               end
               zero_in = nz;
            end
            default: begin
            end
         endcase
      end
   end

   assign out_free = ~rsp_valid_ff | ~rsp_stall;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff  <= req_type;
         raw_ff  <= req_adc_raw;
         now_ff  <= req_now_ms;
         tare_ff <= req_tare_angle;
      end
      if (cmd.pos_mul) begin
         prod_ff    <= DIVW'({raw_range, 8'd0});
         pos_acc_ff <= '0;
      end else if (cmd.pos_fold) begin
         prod_ff    <= fold_sum;
         pos_acc_ff <= pos_acc_ff + fold_hi[pavt_pkg::POS_W-1:0];
      end else if (cmd.vel_mul) begin
         prod_ff <= DIVW'(vel_prod);
      end
      if (cmd.pos_load) begin
         pos_ff <= pos_acc_ff + {{(pavt_pkg::POS_W - 1){1'b0}}, &fold_lo};
      end
      if (cmd.apply) begin
         mv_ff  <= mv;
         el_ff  <= el[AW-1:0];
         vel_ff <= '0;
      end else if (cmd.vel_load) begin
         vel_ff <= vel_in;
      end
      if (cmd.vel_mul) begin
         neg_ff <= mv_ff[RW+1];
      end
      if (cmd.out_load) begin
         rsp_angle_ff <= angle_sat;
         rsp_vel_ff   <= vel_ff;
         rsp_vv_ff    <= vvalid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         range_ff     <= pavt_pkg::RANGE_RESET;
         age_ff       <= pavt_pkg::AGE_RESET;
         track_ff     <= pavt_pkg::TRACK_RESET;
         zero_ff      <= '0;
         ref_pos0_ff  <= '0;
         ref_pos1_ff  <= '0;
         ref_time0_ff <= '0;
         ref_time1_ff <= '0;
         sel_ff       <= 1'b0;
         vel_ok_ff    <= 1'b0;
         vvalid_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               pavt_pkg::CSR_RANGE: range_ff <= csr_data[pavt_pkg::RANGE_W-1:0];
               pavt_pkg::CSR_AGE:   age_ff   <= csr_data[AW-1:0];
               pavt_pkg::CSR_TRACK: track_ff <= csr_data[0];
               default: begin
               end
            endcase
         end
         zero_ff      <= zero_in;
         ref_pos0_ff  <= ref_pos0_in;
         ref_pos1_ff  <= ref_pos1_in;
         ref_time0_ff <= ref_time0_in;
         ref_time1_ff <= ref_time1_in;
         sel_ff       <= sel_in;
         if (cmd.apply) begin
            vel_ok_ff <= (req_ff == pavt_pkg::REQ_MEASURE) && ok;
            vvalid_ff <= 1'b0;
         end else if (cmd.vel_load) begin
            vvalid_ff <= 1'b1;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.req_code  = req_ff;
   assign status.fold_done = fold_done;
   assign status.div_done  = div_done;
   assign status.vel_ok    = vel_ok_ff;
   assign status.out_free  = out_free;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_angle          = rsp_angle_ff;
   assign rsp_velocity       = rsp_vel_ff;
   assign rsp_velocity_valid = rsp_vv_ff;

endmodule

`default_nettype wire

// File: hdl/pavt_controller.sv
// Controller state machine of the tracker.
// Sequences capture, position scaling, state update, velocity division and
// the result transfer. Depends on pavt_pkg.
`default_nettype none

module pavt_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  pavt_pkg::status_type status,
   output pavt_pkg::cmd_type    cmd
);

   pavt_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pavt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         pavt_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = pavt_pkg::ST_POS_MUL;
            end
         end
         pavt_pkg::ST_POS_MUL: begin
            cmd.pos_mul = 1'b1;
            state_in    = pavt_pkg::ST_POS_FOLD;
         end
         pavt_pkg::ST_POS_FOLD: begin
            if (status.fold_done) begin
               cmd.pos_load = 1'b1;
               state_in     = pavt_pkg::ST_APPLY;
            end else begin
               cmd.pos_fold = 1'b1;
            end
         end
         pavt_pkg::ST_APPLY: begin
            cmd.apply = 1'b1;
            if (status.req_code == pavt_pkg::REQ_MEASURE) begin
               state_in = pavt_pkg::ST_VEL_MUL;
            end else begin
               state_in = pavt_pkg::ST_FINISH;
            end
         end
         pavt_pkg::ST_VEL_MUL: begin
            if (status.vel_ok) begin
               cmd.vel_mul = 1'b1;
               state_in    = pavt_pkg::ST_VEL_DIV;
            end else begin
               state_in = pavt_pkg::ST_FINISH;
            end
         end
         pavt_pkg::ST_VEL_DIV: begin
            cmd.div_start = 1'b1;
            state_in      = pavt_pkg::ST_VEL_WAIT;
         end
         pavt_pkg::ST_VEL_WAIT: begin
            if (status.div_done) begin
               cmd.vel_load = 1'b1;
               state_in     = pavt_pkg::ST_FINISH;
            end
         end
         pavt_pkg::ST_FINISH: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = pavt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pavt_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: hdl/pot_angle_velocity_tracker.sv
// Potentiometer angle and velocity tracker, top level.
// A tick, a tare or a measure without a usable reference skips the velocity division.
// At ADC_BITS 10 up to three folds scale the reading; a measure with a live reference
// then runs the bit-serial velocity divider over DIVW = max(ADC_BITS + 17, 32) bits.
// A stalled result delays the transfer of the following result.
// A new item is taken while the previous result waits; synchronous reset restores defaults.
`default_nettype none

module pot_angle_velocity_tracker #(
   parameter int unsigned ADC_BITS = pavt_pkg::ADC_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [pavt_pkg::REQ_W-1:0]          req_type,
   input  logic [ADC_BITS-1:0]                 req_adc_raw,
   input  logic [pavt_pkg::TIME_W-1:0]         req_now_ms,
   input  logic signed [pavt_pkg::TARE_W-1:0]  req_tare_angle,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [pavt_pkg::ANGLE_W-1:0] rsp_angle,
   output logic signed [pavt_pkg::VEL_W-1:0]   rsp_velocity,
   output logic                                rsp_velocity_valid,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pavt_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pavt_pkg::CSR_DAT_W-1:0]      csr_data
);

   pavt_pkg::cmd_type    cmd;
   pavt_pkg::status_type status;

   assign csr_ready = 1'b1;

   pavt_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   pavt_datapath #(.ADC_BITS(ADC_BITS)) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_type           (req_type),
      .req_adc_raw        (req_adc_raw),
      .req_now_ms         (req_now_ms),
      .req_tare_angle     (req_tare_angle),
      .csr_write          (csr_valid & csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_angle          (rsp_angle),
      .rsp_velocity       (rsp_velocity),
      .rsp_velocity_valid (rsp_velocity_valid)
   );

endmodule

`default_nettype wire

// File: hdl/pavt_checker.sv
// Port-level checker for the tracker, bound to the top level.
// Watches the request and result transfers. Depends on pavt_pkg.
`default_nettype none

module pavt_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic signed [pavt_pkg::ANGLE_W-1:0] rsp_angle,
   input logic signed [pavt_pkg::VEL_W-1:0]   rsp_velocity,
   input logic                                rsp_velocity_valid
);

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("result or busy flag survives reset");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while a previous one is in progress");

   a_zero_when_invalid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_velocity_valid |-> rsp_velocity == '0)
      else $error("velocity not zero while flagged invalid");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_angle)
         && $stable(rsp_velocity) && $stable(rsp_velocity_valid))
      else $error("stalled result changed");

endmodule

bind pot_angle_velocity_tracker pavt_checker u_pavt_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_angle          (rsp_angle),
   .rsp_velocity       (rsp_velocity),
   .rsp_velocity_valid (rsp_velocity_valid)
);

`default_nettype wire
